[hw/rtl/u8ld_pkg.sv]
// shared types and constants for the legacy six-byte utf-8 decoder
// no dependencies; imported by every decoder module
`default_nettype none

package u8ld_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 31;
  localparam int unsigned LenW   = 3;
  localparam int unsigned ContW  = 6;

  // default depth of the queue between classifier and assembler
  localparam int unsigned QueueDepthDefault = 2;

  // sequence lengths
  localparam logic [LenW-1:0] LenOne   = 3'd1;
  localparam logic [LenW-1:0] LenTwo   = 3'd2;
  localparam logic [LenW-1:0] LenThree = 3'd3;
  localparam logic [LenW-1:0] LenFour  = 3'd4;
  localparam logic [LenW-1:0] LenFive  = 3'd5;
  localparam logic [LenW-1:0] LenSix   = 3'd6;
  localparam logic [LenW-1:0] LenNone  = 3'd0;

  // lead byte thresholds
  localparam logic [ByteW-1:0] LeadSix   = 8'hFC;
  localparam logic [ByteW-1:0] LeadFive  = 8'hF8;
  localparam logic [ByteW-1:0] LeadFour  = 8'hF0;
  localparam logic [ByteW-1:0] LeadThree = 8'hE0;
  localparam logic [ByteW-1:0] LeadTwo   = 8'hC0;

  // payload masks
  localparam logic [ByteW-1:0] MaskSix   = 8'h01;
  localparam logic [ByteW-1:0] MaskFive  = 8'h03;
  localparam logic [ByteW-1:0] MaskFour  = 8'h07;
  localparam logic [ByteW-1:0] MaskThree = 8'h0F;
  localparam logic [ByteW-1:0] MaskTwo   = 8'h1F;
  localparam logic [ByteW-1:0] MaskCont  = 8'h3F;

  // one classified byte, as queued between front and back
  typedef struct packed {
    logic             lead;  // starts a new sequence
    logic             last;  // closes the sequence, a result follows
    logic [LenW-1:0]  len;   // sequence length, lead bytes only
    logic [ByteW-1:0] data;  // masked payload bits
  } entry_t;

endpackage

`default_nettype wire

[hw/rtl/u8ld_front.sv]
// classifier: tracks sequence position and tags each byte as lead or continuation
// depends on u8ld_pkg
`default_nettype none

module u8ld_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [u8ld_pkg::ByteW-1:0] byte_in,
  input  wire logic                     q_full,
  output logic                          q_push,
  output u8ld_pkg::entry_t              q_entry
);
  import u8ld_pkg::*;

  logic [LenW-1:0] bytes_left;
  logic [LenW-1:0] bytes_left_next;
  logic [LenW-1:0] lead_len;
  logic [ByteW-1:0] lead_data;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    priority if (byte_in >= LeadSix) begin
      lead_len = LenSix;   lead_data = byte_in & MaskSix;
    end else if (byte_in >= LeadFive) begin
      lead_len = LenFive;  lead_data = byte_in & MaskFive;
    end else if (byte_in >= LeadFour) begin
      lead_len = LenFour;  lead_data = byte_in & MaskFour;
    end else if (byte_in >= LeadThree) begin
      lead_len = LenThree; lead_data = byte_in & MaskThree;
    end else if (byte_in >= LeadTwo) begin
      lead_len = LenTwo;   lead_data = byte_in & MaskTwo;
    end else begin
      lead_len = LenOne;   lead_data = byte_in;
    end
  end

  always_comb begin
    if (bytes_left == LenNone) begin
      q_entry.lead    = 1'b1;
      q_entry.last    = (lead_len == LenOne);
      q_entry.len     = lead_len;
      q_entry.data    = lead_data;
      bytes_left_next = lead_len - LenOne;
    end else begin
      q_entry.lead    = 1'b0;
      q_entry.last    = (bytes_left == LenOne);
      q_entry.len     = LenNone;
      q_entry.data    = byte_in & MaskCont;
      bytes_left_next = bytes_left - LenOne;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= LenNone;
    end else if (q_push) begin
      bytes_left <= bytes_left_next;
    end
  end

  // at most five continuation bytes ever outstanding
  a_left_range: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= LenFive)
    else $error("bytes_left out of range");

  // a lead byte is only tagged when no sequence is open
  a_lead_idle: assert property (@(posedge clk) disable iff (rst)
    q_push && q_entry.lead |-> bytes_left == LenNone)
    else $error("lead tagged inside a sequence");

  // last continuation closes the sequence
  a_close: assert property (@(posedge clk) disable iff (rst)
    q_push && !q_entry.lead && q_entry.last |=> bytes_left == LenNone)
    else $error("sequence not closed after last byte");

endmodule

`default_nettype wire

[hw/rtl/u8ld_queue.sv]
// small fifo of classified bytes between classifier and assembler
// depends on u8ld_pkg
`default_nettype none

module u8ld_queue #(
  parameter int unsigned Depth = u8ld_pkg::QueueDepthDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire u8ld_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output u8ld_pkg::entry_t      head,
  output logic                  empty
);
  import u8ld_pkg::*;

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam logic [AddrW-1:0]  LastAddr  = AddrW'(Depth - 1);
  localparam logic [CountW-1:0] DepthCnt  = CountW'(Depth);

  entry_t            mem [Depth];
  logic [AddrW-1:0]  wr_ptr;
  logic [AddrW-1:0]  rd_ptr;
  logic [CountW-1:0] count;

  assign full  = (count == DepthCnt);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastAddr) ? '0 : wr_ptr + AddrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastAddr) ? '0 : rd_ptr + AddrW'(1);
      end
      if (push && !pop) begin
        count <= count + CountW'(1);
      end else if (pop && !push) begin
        count <= count - CountW'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DepthCnt)
    else $error("queue count overflow");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("queue push when full or pop when empty");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CountW'(1))
    else $error("queue count did not advance");

endmodule

`default_nettype wire

[hw/rtl/u8ld_back.sv]
// assembler: shifts payload bits into the code point and holds the result register
// depends on u8ld_pkg
`default_nettype none

module u8ld_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire u8ld_pkg::entry_t          head,
  input  wire logic                      q_empty,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [u8ld_pkg::CodeW-1:0]     code_point,
  output logic [u8ld_pkg::LenW-1:0]      seq_length
);
  import u8ld_pkg::*;

  logic [CodeW-1:0] accumulator;
  logic [LenW-1:0]  length_seen;
  logic [CodeW-1:0] accumulator_next;
  logic [LenW-1:0]  length_seen_next;

  // take a queued byte whenever the result register is free or draining
  assign q_pop = !q_empty && (!out_valid || out_ready);

  always_comb begin
    if (head.lead) begin
      accumulator_next = CodeW'(head.data);
      length_seen_next = head.len;
    end else begin
      accumulator_next = {accumulator[CodeW-ContW-1:0], head.data[ContW-1:0]};
      length_seen_next = length_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      length_seen <= LenNone;
    end else if (q_pop) begin
      accumulator <= accumulator_next;
      length_seen <= length_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= head.last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && head.last) begin
      code_point <= accumulator_next;
      seq_length <= length_seen_next;
    end
  end

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (seq_length >= LenOne && seq_length <= LenSix))
    else $error("result length out of range");

  a_single_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && seq_length == LenOne |-> code_point < CodeW'(256))
    else $error("one-byte result wider than a byte");

  a_emit_on_last: assert property (@(posedge clk) disable iff (rst)
    q_pop && head.last |=> out_valid)
    else $error("last byte produced no result");

endmodule

`default_nettype wire

[hw/rtl/utf8_legacy_decoder_top.sv]
// top level of the legacy six-byte utf-8 decoder
// depends on u8ld_pkg, u8ld_front, u8ld_queue, u8ld_back
`default_nettype none

// byte-serial decoder for the original utf-8 form with lead bytes up to six
// bytes long. one byte is taken per cycle on the input channel while the
// queue has room; a result item (code point and sequence length) leaves on
// the output channel when the last byte of a sequence has been taken. a lead
// byte from c0 up opens a sequence of two to six bytes, anything below c0
// (stray continuation bytes included) is a one-byte code point. bytes inside
// a sequence are never checked, only their low six bits are used. sustained
// rate is one byte per cycle while the receiver keeps taking results; an
// accepted byte passes through the classifier queue and then the assembler's
// result register. the classifier keeps taking bytes while a result waits,
// until the queue (QueueDepth entries) is full.
module utf8_legacy_decoder_top #(
  parameter int unsigned QueueDepth = u8ld_pkg::QueueDepthDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // byte input
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [u8ld_pkg::ByteW-1:0] byte_in,
  // decoded result
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [u8ld_pkg::CodeW-1:0]     code_point,
  output logic [u8ld_pkg::LenW-1:0]      seq_length
);
  import u8ld_pkg::*;

  // classified bytes between front and back
  entry_t push_entry;
  entry_t head;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;

  // front: tracks how many continuation bytes remain and tags each byte
  u8ld_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .byte_in  (byte_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  // decoupling queue so each side stalls on its own
  u8ld_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty)
  );

  // back: builds the code point and presents it in the result register
  u8ld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .seq_length (seq_length)
  );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking bench for the legacy six-byte utf-8 decoder top level
// depends on u8ld_pkg and utf8_legacy_decoder_top; nothing else is read
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u8ld_pkg::*;

  // clock, reset and run length
  localparam int unsigned ClkPeriod  = 4;
  localparam int unsigned RstCycles  = 9;
  localparam int unsigned TotalItems = 1600;
  localparam int unsigned HoldAt     = 500;   // items in when the receiver holds off
  localparam int unsigned LongHold   = 300;   // cycles of that hold-off
  localparam int unsigned DrainAt    = 1000;  // items in when the sender pauses to drain
  localparam int unsigned TailCycles = 16;    // margin for stray results after the last owed one
  localparam int unsigned TimeLimit  = 4_000_000;

  // one decoded code point as it leaves the block
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } cp_result_t;

  // one row of the directed table; fixed rows carry a hand-worked result
  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             fixed;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } dir_row_t;

  localparam int unsigned NumDirRows = 26;
  localparam dir_row_t DirRows [NumDirRows] = '{
    // one-byte code points at the extremes, stray continuation byte last
    '{8'h00, 1'b1, 31'h0000_0000, LenOne},
    '{8'h7F, 1'b1, 31'h0000_007F, LenOne},
    '{8'h80, 1'b1, 31'h0000_0080, LenOne},
    // smallest two-byte lead with largest continuation
    '{8'hC0, 1'b0, 31'h0, LenNone},
    '{8'hBF, 1'b1, 31'h0000_003F, LenTwo},
    // four-byte sequence with a lead-looking byte and a c0 inside it
    '{8'hF0, 1'b0, 31'h0, LenNone},
    '{8'hFE, 1'b0, 31'h0, LenNone},
    '{8'h80, 1'b0, 31'h0, LenNone},
    '{8'hC0, 1'b0, 31'h0, LenNone},
    // 0xff as a six-byte lead, every payload bit set
    '{8'hFF, 1'b0, 31'h0, LenNone},
    '{8'hBF, 1'b0, 31'h0, LenNone},
    '{8'hBF, 1'b0, 31'h0, LenNone},
    '{8'hBF, 1'b0, 31'h0, LenNone},
    '{8'hBF, 1'b0, 31'h0, LenNone},
    '{8'hBF, 1'b1, 31'h7FFF_FFFF, LenSix},
    // 0xfe as a six-byte lead, overlong zero
    '{8'hFE, 1'b0, 31'h0, LenNone},
    '{8'h80, 1'b0, 31'h0, LenNone},
    '{8'h80, 1'b0, 31'h0, LenNone},
    '{8'h80, 1'b0, 31'h0, LenNone},
    '{8'h80, 1'b0, 31'h0, LenNone},
    '{8'h80, 1'b1, 31'h0000_0000, LenSix},
    // five-byte overlong zero
    '{8'hF8, 1'b0, 31'h0, LenNone},
    '{8'h80, 1'b0, 31'h0, LenNone},
    '{8'h80, 1'b0, 31'h0, LenNone},
    '{8'h80, 1'b0, 31'h0, LenNone},
    '{8'h80, 1'b1, 31'h0000_0000, LenFive}
  };

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [ByteW-1:0] byte_in;
  logic             out_valid;
  logic             out_ready;
  logic [CodeW-1:0] code_point;
  logic [LenW-1:0]  seq_length;

  // decoder state mirrored by the predictor
  logic [LenW-1:0]  dec_left;
  logic [CodeW-1:0] dec_acc;
  logic [LenW-1:0]  dec_len;

  cp_result_t  expected_cps[$];   // code points still owed by the block
  int unsigned mismatches = 0;
  int unsigned items_in   = 0;    // bytes accepted so far
  bit          tx_burst   = 1'b0; // sender offers back to back while set

  always #(ClkPeriod / 2) clk = ~clk;

  utf8_legacy_decoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .seq_length (seq_length)
  );

  // one line per mismatch, counted toward the final verdict
  task automatic report_mismatch(input string what, input logic [CodeW-1:0] got,
                                 input logic [CodeW-1:0] want);
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // advance the decoder by one byte; done is set when a code point completes
  task automatic decode_byte(input logic [ByteW-1:0] b, output bit done,
                             output cp_result_t res);
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] payload;
    done = 1'b0;
    res  = '0;
    if (dec_left != LenNone) begin
      // inside a sequence: no check at all, low six bits shift in
      dec_acc  = {dec_acc[CodeW-ContW-1:0], b[ContW-1:0]};
      dec_left = dec_left - LenOne;
      if (dec_left == LenNone) begin
        done     = 1'b1;
        res.code = dec_acc;
        res.len  = dec_len;
      end
    end else begin
      // idle: the byte picks the length and gives the first payload bits
      if (b >= LeadSix) begin
        len = LenSix;   payload = b & MaskSix;
      end else if (b >= LeadFive) begin
        len = LenFive;  payload = b & MaskFive;
      end else if (b >= LeadFour) begin
        len = LenFour;  payload = b & MaskFour;
      end else if (b >= LeadThree) begin
        len = LenThree; payload = b & MaskThree;
      end else if (b >= LeadTwo) begin
        len = LenTwo;   payload = b & MaskTwo;
      end else begin
        // ascii and stray continuation bytes alike stand for themselves
        len = LenOne;   payload = b;
      end
      dec_acc = CodeW'(payload);
      dec_len = len;
      if (len == LenOne) begin
        done     = 1'b1;
        res.code = dec_acc;
        res.len  = LenOne;
      end else begin
        dec_left = len - LenOne;
      end
    end
  endtask

  // idle cycles before the next item: mostly none or a few, now and then many
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (tx_burst || roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one item and hold it until taken; the expectation is queued at
  // the accepting edge, either the hand-worked one or the predicted one
  task automatic send_byte(input logic [ByteW-1:0] b, input bit fixed,
                           input cp_result_t fixed_res);
    int unsigned gap;
    bit          done;
    cp_result_t  res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_in++;
    decode_byte(b, done, res);
    if (fixed) expected_cps.push_back(fixed_res);
    else if (done) expected_cps.push_back(res);
  endtask

  // random sequence: lead byte of a random class, then continuation bytes;
  // cut short or filled with arbitrary bytes when asked
  task automatic send_sequence(input bit cut_short, input bit broken);
    logic [LenW-1:0]  seq_len;
    logic [ByteW-1:0] lead;
    logic [ByteW-1:0] cont;
    int unsigned      n_cont;
    seq_len = LenOne + LenW'($urandom_range(0, 5));
    case (seq_len)
      LenOne:   lead = ByteW'($urandom_range(0, LeadTwo - 1));
      LenTwo:   lead = ByteW'($urandom_range(LeadTwo, LeadThree - 1));
      LenThree: lead = ByteW'($urandom_range(LeadThree, LeadFour - 1));
      LenFour:  lead = ByteW'($urandom_range(LeadFour, LeadFive - 1));
      LenFive:  lead = ByteW'($urandom_range(LeadFive, LeadSix - 1));
      default:  lead = ByteW'($urandom_range(LeadSix, {ByteW{1'b1}}));
    endcase
    n_cont = seq_len - 1;
    // a cut-short sequence lets the next lead byte fall in as a continuation
    if (cut_short && n_cont > 0) n_cont = $urandom_range(0, n_cont - 1);
    send_byte(lead, 1'b0, '0);
    repeat (n_cont) begin
      if (broken && $urandom_range(0, 2) == 0) cont = ByteW'($urandom_range(0, 255));
      else cont = ByteW'($urandom_range(8'h80, 8'hBF));
      send_byte(cont, 1'b0, '0);
    end
  endtask

  // receiver: random stalls, calm stretches, and one long hold-off once the
  // sender is well into the run so the queue fills and in_ready drops
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned roll;
    bit          held;
    stall_left = 0;
    calm_left  = 0;
    held       = 1'b0;
    out_ready  = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && items_in >= HoldAt) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      if (calm_left > 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          calm_left = $urandom_range(50, 150);
          out_ready <= 1'b1;
        end else if (roll < 25) begin
          // this cycle is the first of the stall
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // checker: every taken result must match the oldest owed code point,
  // both fields compared; values are those from before the edge
  always @(posedge clk) begin : result_check
    cp_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_cps.size() == 0) begin
        report_mismatch("result with nothing owed", code_point, '0);
      end else begin
        want = expected_cps.pop_front();
        if (code_point !== want.code)
          report_mismatch("code_point", code_point, want.code);
        if (seq_length !== want.len)
          report_mismatch("seq_length", CodeW'(seq_length), CodeW'(want.len));
      end
    end
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #(TimeLimit);
    $display("simulation failed");
    $finish;
  end

  // main stimulus: reset, directed table, random sequences, drain, verdict
  initial begin : stimulus
    int unsigned kind;
    bit          drained;
    cp_result_t  fixed_res;
    drained  = 1'b0;
    rst      = 1'b1;
    in_valid = 1'b0;
    byte_in  = '0;
    // predictor starts from the reset state
    dec_left = LenNone;
    dec_acc  = '0;
    dec_len  = LenNone;
    repeat (RstCycles) @(posedge clk);
    rst <= 1'b0;

    // directed part: extremes, leads c0, f0, f8, fe and ff, malformed and
    // overlong sequences; hand-worked rows override the predictor
    for (int i = 0; i < NumDirRows; i++) begin
      fixed_res.code = DirRows[i].code;
      fixed_res.len  = DirRows[i].len;
      send_byte(DirRows[i].b, DirRows[i].fixed, fixed_res);
    end

    // random part: mostly well-formed sequences with random content, the
    // rest lone noise bytes, cut-short and broken sequences
    while (items_in < TotalItems) begin
      tx_burst = ($urandom_range(0, 9) < 2);
      if (!drained && items_in >= DrainAt) begin
        // sender pause until every owed code point has come out
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_cps.size() != 0);
      end
      kind = $urandom_range(0, 99);
      if (kind < 8) send_byte(ByteW'($urandom_range(0, 255)), 1'b0, '0);
      else send_sequence(kind < 16, kind >= 16 && kind < 28);
    end
    in_valid <= 1'b0;

    // wait for the last results, then a few more cycles for strays
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
